// ===== rtl/hcrt_pkg.sv =====
// Shared types and constants for the hop count route table update block.
// Used by the top level and hcrt_match; depends on nothing.
package hcrt_pkg;

  localparam int ROUTE_ENTRIES_DEF = 16;
  localparam int ADDR_W = 8;
  localparam int METRIC_W = 8;
  localparam int SLOT_W = 4;
  localparam int TOTAL_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC_MODE = 2'd1;

  localparam logic [METRIC_W-1:0] METRIC_MAX = 8'hFF;
  localparam logic [METRIC_W-1:0] METRIC_NEIGHBOR = 8'd1;

  typedef enum logic [2:0] {
    ACT_IGNORED  = 3'd0,
    ACT_IMPROVED = 3'd1,
    ACT_KEPT     = 3'd2,
    ACT_INSERTED = 3'd3,
    ACT_FULL     = 3'd4
  } action_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   dest;
    logic [METRIC_W-1:0] metric;
    logic [ADDR_W-1:0]   next_hop;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic better;
  } match_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

// ===== rtl/hop_count_route_table_update.sv =====
// Hop count route table update: top level, sequencer and configuration registers.
// Steps: an ignored offer gives its result straight from idle; otherwise the sequencer reads
// the stored routes in order, ends on the first hit, and after a miss over every stored route
// inserts the route or reports full. One route RAM read per cycle; busy is high while scanning.
// Throughput: one item at a time. The result strobe cannot be stalled.
// Reset (rst, synchronous): empty table, local_address 0, metric_mode 0.
module hop_count_route_table_update #(
  parameter int ROUTE_ENTRIES = hcrt_pkg::ROUTE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             kind,
  input  logic [hcrt_pkg::ADDR_W-1:0]      sender,
  input  logic [hcrt_pkg::ADDR_W-1:0]      destination,
  input  logic [hcrt_pkg::METRIC_W-1:0]    advertised_metric,
  output logic                             done,
  output logic [2:0]                       action,
  output logic [hcrt_pkg::SLOT_W-1:0]      slot,
  output logic [hcrt_pkg::TOTAL_W-1:0]     route_total,
  input  logic                             cfg_write,
  input  logic [hcrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hcrt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hcrt_pkg::*;

  localparam int IDX_W = $clog2(ROUTE_ENTRIES);
  localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ROUTE_ENTRIES);

  state_t               state;
  logic [ADDR_W-1:0]    local_address;
  logic                 metric_mode;
  logic [ADDR_W-1:0]    item_addr;
  logic [METRIC_W-1:0]  item_hop;
  logic [ADDR_W-1:0]    item_via;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     idx;
  logic                 chk_vld;
  logic [IDX_W-1:0]     chk_idx;
  action_t              action_r;

  logic [ADDR_W-1:0]    offer_addr;
  logic [METRIC_W-1:0]  offer_hop;
  logic [ADDR_W-1:0]    offer_via;
  logic                 offer_ignore;
  logic                 found;
  logic                 scan_miss;
  logic                 issue;
  logic                 has_room;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  entry_t               ram_rdata;
  match_t               match;
  logic [CNT_W-1:0]     count_inc;
  logic [IDX_W+SLOT_W-1:0]  found_slot_ext;
  logic [IDX_W+SLOT_W-1:0]  ins_slot_ext;
  logic [CNT_W+TOTAL_W-1:0] total_now_ext;
  logic [CNT_W+TOTAL_W-1:0] total_inc_ext;

  hcrt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ROUTE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  hcrt_match u_match (
    .addr  (item_addr),
    .hop   (item_hop),
    .entry (ram_rdata),
    .result(match)
  );

  always_comb begin
    offer_addr = kind ? destination : sender;
    offer_via  = kind ? sender : local_address;
    if (!kind) begin
      offer_hop = METRIC_NEIGHBOR;
    end else if (advertised_metric == METRIC_MAX) begin
      offer_hop = METRIC_MAX;
    end else begin
      offer_hop = advertised_metric + METRIC_NEIGHBOR;
    end
    offer_ignore = metric_mode || (offer_addr == '0) || (offer_addr == local_address);
  end

  assign busy      = (state != ST_IDLE);
  assign found     = (state == ST_SCAN) && chk_vld && match.hit;
  assign scan_miss = (state == ST_SCAN) && !chk_vld && (idx == count);
  assign issue     = (state == ST_SCAN) && !found && (idx != count);
  assign has_room  = (count != FULL_COUNT);
  assign count_inc = count + CNT_W'(1);

  assign ram_we    = (found && match.better) || (scan_miss && has_room);
  assign ram_waddr = found ? chk_idx : count[IDX_W-1:0];
  assign ram_wdata = '{dest: item_addr, metric: item_hop, next_hop: item_via};

  assign found_slot_ext = {{SLOT_W{1'b0}}, chk_idx};
  assign ins_slot_ext   = {{SLOT_W{1'b0}}, count[IDX_W-1:0]};
  assign total_now_ext  = {{TOTAL_W{1'b0}}, count};
  assign total_inc_ext  = {{TOTAL_W{1'b0}}, count_inc};

  assign action = action_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      local_address <= '0;
      metric_mode   <= 1'b0;
      count         <= '0;
      idx           <= '0;
      chk_vld       <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_LOCAL_ADDRESS: local_address <= cfg_data[ADDR_W-1:0];
          REG_METRIC_MODE:   metric_mode   <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            item_addr <= offer_addr;
            item_hop  <= offer_hop;
            item_via  <= offer_via;
            if (offer_ignore) begin
              done        <= 1'b1;
              action_r    <= ACT_IGNORED;
              slot        <= '0;
              route_total <= total_now_ext[TOTAL_W-1:0];
            end else begin
              state   <= ST_SCAN;
              idx     <= '0;
              chk_vld <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          priority if (found) begin
            done        <= 1'b1;
            action_r    <= match.better ? ACT_IMPROVED : ACT_KEPT;
            slot        <= found_slot_ext[SLOT_W-1:0];
            route_total <= total_now_ext[TOTAL_W-1:0];
            chk_vld     <= 1'b0;
            state       <= ST_IDLE;
          end else if (scan_miss) begin
            done <= 1'b1;
            if (has_room) begin
              count       <= count_inc;
              action_r    <= ACT_INSERTED;
              slot        <= ins_slot_ext[SLOT_W-1:0];
              route_total <= total_inc_ext[TOTAL_W-1:0];
            end else begin
              action_r    <= ACT_FULL;
              slot        <= '0;
              route_total <= total_now_ext[TOTAL_W-1:0];
            end
            state <= ST_IDLE;
          end else begin
            chk_vld <= issue;
            chk_idx <= idx[IDX_W-1:0];
            if (issue) begin
              idx <= idx + CNT_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/hcrt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module hcrt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hcrt_match.sv =====
// Compare unit: checks one stored route against the offer in flight.
// Depends on hcrt_pkg.
module hcrt_match (
  input  logic [hcrt_pkg::ADDR_W-1:0]   addr,
  input  logic [hcrt_pkg::METRIC_W-1:0] hop,
  input  hcrt_pkg::entry_t              entry,
  output hcrt_pkg::match_t              result
);
  import hcrt_pkg::*;

  assign result.hit    = (entry.dest == addr);
  assign result.better = (hop < entry.metric);

endmodule
